// ===== rtl/quadrature_carrier_am_modulator_defines.svh =====
// Assertion macros for the quadrature carrier AM modulator.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef QUADRATURE_CARRIER_AM_MODULATOR_DEFINES_SVH
`define QUADRATURE_CARRIER_AM_MODULATOR_DEFINES_SVH

// Condition holds at every clock edge outside reset
`define QCAM_ASSERT_NOW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("%m: check failed");

// Antecedent implies consequent in the same cycle
`define QCAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Antecedent implies consequent in the next cycle
`define QCAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== rtl/qcam_pkg.sv =====
// Shared constants, types and the sine table builder for the quadrature
// carrier AM modulator. No dependencies.
`default_nettype none

package qcam_pkg;

	// Sizing
	localparam int SAMPLE_BITS    = 16;
	localparam int PERIOD_MAX     = 4096;
	localparam int SINE_ROM_DEPTH = 1024;

	// Register field widths
	localparam int PERIOD_W  = 13;
	localparam int PHASE_W   = 16;
	localparam int MOD_W     = 15;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Derived widths
	localparam int INDEX_W    = $clog2(PERIOD_MAX);
	localparam int P_W        = $clog2(4 * SINE_ROM_DEPTH);   // full-wave address
	localparam int OFS_W      = P_W - 2;                       // offset in a quadrant
	localparam int ROM_AW     = $clog2(SINE_ROM_DEPTH + 1);
	localparam int MAG_W      = SAMPLE_BITS - 1;
	localparam int FULL_SCALE = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int GAIN_W     = MOD_W + SAMPLE_BITS + 1;
	localparam int GAIN_SHIFT = 12 + SAMPLE_BITS - 1;
	localparam int PROD_W     = MAG_W + GAIN_W;

	// Bias = floor(x / 10) by reciprocal, exact for x below 2^32
	localparam int BIAS_X_W             = MOD_W + SAMPLE_BITS;
	localparam int RECIP_W              = 32;
	localparam logic [RECIP_W-1:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SHIFT        = 35;
	localparam int BIAS_W               = BIAS_X_W + RECIP_W - RECIP10_SHIFT;

	// Hand-off queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 13'd8;
	localparam logic [PHASE_W-1:0]  STEP_RST   = 16'd8192;
	localparam logic [MOD_W-1:0]    MOD_RST    = 15'd4096;
	localparam logic                AM_RST     = 1'b0;

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_LEN = 2'd0,
		REG_PHASE_STEP = 2'd1,
		REG_MOD_INDEX  = 2'd2,
		REG_AM_ENABLE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_len;
		logic [PHASE_W-1:0]  phase_step;
		logic [MOD_W-1:0]    mod_index;
		logic                am_enable;
	} cfg_t;

	// One classified sample waiting for the back end
	typedef struct packed {
		logic [ROM_AW-1:0]             sin_addr;
		logic                          sin_neg;
		logic [ROM_AW-1:0]             cos_addr;
		logic                          cos_neg;
		logic signed [SAMPLE_BITS-1:0] baseband;
		logic                          last;
	} item_t;

	typedef struct packed {
		logic [FIFO_AW:0] count;
		logic             full;
		logic             empty;
	} fifo_stat_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_acc;
		logic               wrap;
		logic               accept;
	} front_stat_t;

	typedef logic [MAG_W-1:0] sine_rom_t [0:SINE_ROM_DEPTH];

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	// Quarter-wave sine table, Taylor series in Q2.30, rounded half up,
	// capped at full scale. Evaluated at elaboration only.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		for (int j = 0; j <= SINE_ROM_DEPTH; j++) begin
			x = (HALF_PI_Q30 * 64'(j)) / SINE_ROM_DEPTH;
			x2 = (x * x) >> 30;
			t = Q30_ONE;
			for (int k = 0; k < 6; k++) begin
				t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[k];
			end
			s = (x * t) >> 30;
			v = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
			if (v > 64'(FULL_SCALE)) begin
				v = 64'(FULL_SCALE);
			end
			rom[j] = v[MAG_W-1:0];
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/qcam_front.sv =====
// Front end: takes baseband samples, advances the sample index and phase,
// and turns the phase into folded sine/cosine table addresses. Uses qcam_pkg.
`default_nettype none

module qcam_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire qcam_pkg::cfg_t                   cfg,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [qcam_pkg::SAMPLE_BITS-1:0] s_tdata,   // [15:0] baseband
	input  wire logic                             s_tlast,   // block_last
	input  wire logic                             q_full,
	output logic                                  push,
	output qcam_pkg::item_t                       push_item,
	output qcam_pkg::front_stat_t                 stat
);
	import qcam_pkg::*;

	logic [INDEX_W-1:0]       index_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [PERIOD_W-1:0]      per;
	logic [PERIOD_W-1:0]      index_inc;
	logic [PHASE_W-1:0]       phase_new;
	logic                     wrap;
	logic [PHASE_W+P_W-1:0]   p_wide;
	logic [P_W-1:0]           p_sin;
	logic [P_W-1:0]           p_cos;

	// Fold a full-wave address onto the quarter-wave table
	function automatic logic [ROM_AW-1:0] fold_addr(input logic [P_W-1:0] p);
		logic [ROM_AW-1:0] r;
		r = ROM_AW'(p[OFS_W-1:0]);
		if (p[OFS_W]) begin
			return ROM_AW'(SINE_ROM_DEPTH) - r;
		end
		return r;
	endfunction

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Period clamp and wrap decision
	assign per       = (cfg.period_len > PERIOD_W'(PERIOD_MAX)) ? PERIOD_W'(PERIOD_MAX)
	                                                             : cfg.period_len;
	assign index_inc = PERIOD_W'(index_q) + PERIOD_W'(1);
	assign wrap      = (index_inc >= per);
	assign phase_new = phase_q + cfg.phase_step;

	// Phase to full-wave address; cosine leads by a quarter turn
	assign p_wide = (PHASE_W+P_W)'(phase_new) * (PHASE_W+P_W)'(4 * SINE_ROM_DEPTH);
	assign p_sin  = p_wide[PHASE_W+P_W-1:PHASE_W];
	assign p_cos  = p_sin + P_W'(SINE_ROM_DEPTH);

	always_comb begin
		push_item.sin_addr = fold_addr(p_sin);
		push_item.sin_neg  = p_sin[P_W-1];
		push_item.cos_addr = fold_addr(p_cos);
		push_item.cos_neg  = p_cos[P_W-1];
		push_item.baseband = s_tdata;
		push_item.last     = s_tlast;
	end

	// Index and phase advance once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			phase_q <= '0;
		end else if (push) begin
			if (wrap) begin
				index_q <= '0;
				phase_q <= '0;
			end else begin
				index_q <= index_inc[INDEX_W-1:0];
				phase_q <= phase_new;
			end
		end
	end

	assign stat.phase_acc = phase_q;
	assign stat.wrap      = wrap;
	assign stat.accept    = push;

endmodule

`default_nettype wire

// ===== rtl/qcam_fifo.sv =====
// Short hand-off queue between the front and back ends.
// Carries qcam_pkg::item_t entries; uses qcam_pkg.
`default_nettype none

module qcam_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire qcam_pkg::item_t  wr_item,
	input  wire logic             pop,
	output qcam_pkg::item_t       rd_item,
	output qcam_pkg::fifo_stat_t  stat
);
	import qcam_pkg::*;

	item_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	assign rd_item = mem[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

	assign stat.count = count_q;
	assign stat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== rtl/qcam_back.sv =====
// Back end: sine table lookup, AM gain, scaling with rounding and saturation or
// the plain carrier when AM is off, and the output register. Uses qcam_pkg.
`default_nettype none

module qcam_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire qcam_pkg::cfg_t                     cfg,
	input  wire logic                               q_empty,
	input  wire qcam_pkg::item_t                    item,
	output logic                                    pop,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [2*qcam_pkg::SAMPLE_BITS-1:0]      m_tdata,  // [15:0] i_out, [31:16] q_out
	output logic                                    m_tlast   // out_last
);
	import qcam_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam int SCL_W = PROD_W - GAIN_SHIFT + 1;

	logic                      en;
	logic                      valid_s1, valid_s2, valid_s3, out_valid_q;

	logic [BIAS_X_W-1:0]          bias_x;
	logic [BIAS_X_W+RECIP_W-1:0]  bias_prod;
	logic [BIAS_W-1:0]            bias_q;

	logic signed [GAIN_W-1:0]  m_ext;
	logic signed [GAIN_W-1:0]  bb_ext;
	logic signed [GAIN_W-1:0]  gain;

	logic [MAG_W-1:0]          sin_mag_s1, cos_mag_s1;
	logic                      sin_neg_s1, cos_neg_s1, last_s1;
	logic signed [GAIN_W-1:0]  mbb_s1;

	logic [MAG_W-1:0]          sin_mag_s2, cos_mag_s2;
	logic                      sin_neg_s2, cos_neg_s2, last_s2;
	logic                      g_neg_s2;
	logic [GAIN_W-1:0]         g_mag_s2;

	logic [MAG_W-1:0]          sin_mag_s3, cos_mag_s3;
	logic                      sin_neg_s3, cos_neg_s3, last_s3;
	logic                      g_neg_s3;
	logic [PROD_W-1:0]         prod_i_s3, prod_q_s3;

	logic [SAMPLE_BITS-1:0]    i_q, q_q;
	logic                      last_q;

	// Round half away from zero on the magnitude, then saturate and sign
	function automatic logic [SAMPLE_BITS-1:0] scale_out(input logic [PROD_W-1:0] prod,
	                                                     input logic neg);
		logic [PROD_W:0]          rnd;
		logic [SCL_W-1:0]         mag;
		logic [SAMPLE_BITS-1:0]   lim;
		rnd = {1'b0, prod} + ((PROD_W+1)'(1) << (GAIN_SHIFT - 1));
		mag = rnd[PROD_W:GAIN_SHIFT];
		if (!neg && (mag > SCL_W'(FULL_SCALE))) begin
			lim = SAMPLE_BITS'(FULL_SCALE);
		end else if (neg && (mag > SCL_W'(FULL_SCALE + 1))) begin
			lim = SAMPLE_BITS'(FULL_SCALE + 1);
		end else begin
			lim = mag[SAMPLE_BITS-1:0];
		end
		return neg ? (-lim) : lim;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] carrier(input logic [MAG_W-1:0] mag,
	                                                   input logic neg);
		logic [SAMPLE_BITS-1:0] v;
		v = {1'b0, mag};
		return neg ? (-v) : v;
	endfunction

	// Whole pipe moves when the output register is free or being drained
	assign en  = !out_valid_q || m_tready;
	assign pop = en && !q_empty;

	// Gain offset mod_index*2^15/10, rounded; refreshed every cycle
	assign bias_x    = {1'b0, cfg.mod_index, {(SAMPLE_BITS-1){1'b0}}} + BIAS_X_W'(5);
	assign bias_prod = (BIAS_X_W+RECIP_W)'(bias_x) * (BIAS_X_W+RECIP_W)'(RECIP10);

	always_ff @(posedge clk) begin
		bias_q <= bias_prod[BIAS_X_W+RECIP_W-1:RECIP10_SHIFT];
	end

	assign m_ext  = {{(GAIN_W-MOD_W){1'b0}}, cfg.mod_index};
	assign bb_ext = {{(GAIN_W-SAMPLE_BITS){item.baseband[SAMPLE_BITS-1]}}, item.baseband};
	assign gain   = mbb_s1 + $signed({{(GAIN_W-BIAS_W){1'b0}}, bias_q});

	// Valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Stage 1: table read, modulation product
	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s1 <= SINE_ROM[item.sin_addr];
			cos_mag_s1 <= SINE_ROM[item.cos_addr];
			sin_neg_s1 <= item.sin_neg;
			cos_neg_s1 <= item.cos_neg;
			last_s1    <= item.last;
			mbb_s1     <= m_ext * bb_ext;
		end
	end

	// Stage 2: gain with offset, split into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s2 <= sin_mag_s1;
			cos_mag_s2 <= cos_mag_s1;
			sin_neg_s2 <= sin_neg_s1;
			cos_neg_s2 <= cos_neg_s1;
			last_s2    <= last_s1;
			g_neg_s2   <= gain[GAIN_W-1];
			g_mag_s2   <= gain[GAIN_W-1] ? GAIN_W'(-gain) : GAIN_W'(gain);
		end
	end

	// Stage 3: carrier times gain magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s3 <= sin_mag_s2;
			cos_mag_s3 <= cos_mag_s2;
			sin_neg_s3 <= sin_neg_s2;
			cos_neg_s3 <= cos_neg_s2;
			last_s3    <= last_s2;
			g_neg_s3   <= g_neg_s2;
			prod_i_s3  <= PROD_W'(cos_mag_s2) * PROD_W'(g_mag_s2);
			prod_q_s3  <= PROD_W'(sin_mag_s2) * PROD_W'(g_mag_s2);
		end
	end

	// Output register: scaled result or plain carrier
	always_ff @(posedge clk) begin
		if (en) begin
			if (cfg.am_enable) begin
				i_q <= scale_out(prod_i_s3, cos_neg_s3 ^ g_neg_s3);
				q_q <= scale_out(prod_q_s3, sin_neg_s3 ^ g_neg_s3);
			end else begin
				i_q <= carrier(cos_mag_s3, cos_neg_s3);
				q_q <= carrier(sin_mag_s3, sin_neg_s3);
			end
			last_q <= last_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {q_q, i_q};
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ===== rtl/quadrature_carrier_am_modulator.sv =====
// Quadrature carrier generator with optional AM: top level with the register
// file. Uses qcam_pkg, qcam_front, qcam_fifo, qcam_back and the defines header.
//
// Usage:
//   Slave stream s_*: one signed Q1.15 baseband sample per transfer in
//   s_tdata, s_tlast marks the last sample of a block. Master stream m_*:
//   one I/Q pair per input sample, I (cosine) in m_tdata[15:0], Q (sine) in
//   m_tdata[31:16], m_tlast copies s_tlast. Results leave in input order.
//   Register writes (cfg_we, cfg_index, cfg_data) take effect at once and
//   are meant for times when no sample is in flight.
//   Path: an accepted sample is written to the queue, then moves through
//   stages 1, 2 and 3 and the output register before it shows on m_tvalid.
//   Throughput: one sample per clock while s_tready is high, set by the phase
//   accumulator and sample index update in the front end, one update per transfer.
//   A stalled receiver freezes the back end pipeline and the output
//   register; the four-entry queue keeps accepting until it is full, then
//   s_tready drops.
//   Reset clears the sample index and phase, empties the queue and loads
//   the register defaults: period 8, step 8192, index 4096, AM off.
`default_nettype none

`include "quadrature_carrier_am_modulator_defines.svh"

module quadrature_carrier_am_modulator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [qcam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [qcam_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [qcam_pkg::SAMPLE_BITS-1:0]   s_tdata,   // [15:0] baseband
	input  wire logic                               s_tlast,   // block_last
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [2*qcam_pkg::SAMPLE_BITS-1:0]      m_tdata,   // [15:0] i_out, [31:16] q_out
	output logic                                    m_tlast    // out_last
);
	import qcam_pkg::*;

	cfg_t        cfg_q;
	logic        push;
	logic        pop;
	item_t       push_item;
	item_t       pop_item;
	fifo_stat_t  fifo_stat;
	front_stat_t front_stat;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_len <= PERIOD_RST;
			cfg_q.phase_step <= STEP_RST;
			cfg_q.mod_index  <= MOD_RST;
			cfg_q.am_enable  <= AM_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PERIOD_LEN: cfg_q.period_len <= cfg_data[PERIOD_W-1:0];
				REG_PHASE_STEP: cfg_q.phase_step <= cfg_data[PHASE_W-1:0];
				REG_MOD_INDEX:  cfg_q.mod_index  <= cfg_data[MOD_W-1:0];
				REG_AM_ENABLE:  cfg_q.am_enable  <= cfg_data[0];
			endcase
		end
	end

	qcam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (fifo_stat.full),
		.push      (push),
		.push_item (push_item),
		.stat      (front_stat)
	);

	qcam_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.rd_item (pop_item),
		.stat    (fifo_stat)
	);

	qcam_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (fifo_stat.empty),
		.item     (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Checks
	`QCAM_ASSERT_NEXT(a_wrap_clears_phase, clk, arst_n, front_stat.accept && front_stat.wrap, front_stat.phase_acc == '0)
	`QCAM_ASSERT_NEXT(a_accept_fills_queue, clk, arst_n, s_tvalid && s_tready, !fifo_stat.empty)
	`QCAM_ASSERT_IMP(a_pop_needs_entry, clk, arst_n, pop, fifo_stat.count != '0)
	`QCAM_ASSERT_NOW(a_queue_bounded, clk, arst_n, fifo_stat.count <= (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

`default_nettype wire
